>>> src/pileup_base_counter_top_defines.svh
// ---------------------------------------------------------------------------
// Pileup base counter assertion macros
// Concurrent assertion helpers, left empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef PILEUP_BASE_COUNTER_TOP_DEFINES_SVH
`define PILEUP_BASE_COUNTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PKC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pkc: assertion failed");
`define PKC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pkc: assertion failed");
`else
`define PKC_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define PKC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

>>> src/pkc_pkg.sv
// ---------------------------------------------------------------------------
// Pileup base counter package
// Shared types, codes and default sizes.
// ---------------------------------------------------------------------------
package pkc_pkg;

    localparam int DEFAULT_COUNT_BITS = 20;
    localparam int DEFAULT_INDEL_BITS = 10;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUAL_BITS          = 7;
    localparam int OUT_COUNT_BITS     = 20;

    localparam logic [1:0] ACT_REF    = 2'd0;
    localparam logic [1:0] ACT_SYMBOL = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    localparam logic [2:0] NO_BASE = 3'd4;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic       sample;
        logic [7:0] symbol;
        logic [7:0] quality_char;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                ref_code;
        logic [2:0]                top_base;
        logic [OUT_COUNT_BITS-1:0] top_count_first;
        logic [OUT_COUNT_BITS-1:0] top_count_second;
        logic [2:0]                next_base;
        logic [OUT_COUNT_BITS-1:0] next_count_first;
        logic [OUT_COUNT_BITS-1:0] next_count_second;
    } out_item_t;

    typedef struct packed {
        logic       kind;
        logic       sample;
        logic [1:0] base;
        logic [1:0] ref_code;
        logic       seen;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_rd_t;

endpackage

>>> src/pkc_if.sv
// ---------------------------------------------------------------------------
// Pileup base counter channels
// Valid/ready channels for pileup items, results and configuration.
// ---------------------------------------------------------------------------
interface pkc_in_if import pkc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pkc_out_if import pkc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pkc_cfg_if import pkc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [QUAL_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/pileup_base_counter_top.sv
// ---------------------------------------------------------------------------
// Pileup base counter top level
// Parser front end, operation queue and counter back end.
// ---------------------------------------------------------------------------
// The block accepts one pileup item per clock cycle whenever its four-entry
// operation queue has room; the counter bank drains one queued operation per
// cycle while results are taken, so the sustained rate is then one item per
// cycle. An end-of-position result passes the sum stage, then the rank stage,
// and is held in an output register while the next items are taken.
// The minimum quality register can take a write in any cycle.
`include "pileup_base_counter_top_defines.svh"

module pileup_base_counter_top import pkc_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
    parameter int INDEL_BITS = DEFAULT_INDEL_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    pkc_cfg_if.sink     cfg,
    pkc_in_if.sink      pileup,
    pkc_out_if.source   result
);

    logic  push;
    op_t   push_op;
    logic  q_full;
    logic  q_pop;
    q_rd_t q_rd;

    assign cfg.ready = 1'b1;

    pkc_front #(
        .INDEL_BITS (INDEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.data),
        .item_valid (pileup.valid),
        .item_ready (pileup.ready),
        .item       (pileup.data),
        .push       (push),
        .push_op    (push_op),
        .queue_full (q_full)
    );

    pkc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .rd      (q_rd)
    );

    pkc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q_rd),
        .pop       (q_pop),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (result.data)
    );

    `PKC_ASSERT_NEXT(end_queued_a, clk, rst_n, pileup.valid && pileup.ready && (pileup.data.action == ACT_END), q_rd.valid)
    `PKC_ASSERT_IMPL(pop_needs_entry_a, clk, rst_n, q_pop, q_rd.valid)
    `PKC_ASSERT_IMPL(none_ranks_last_a, clk, rst_n, result.valid && (result.data.top_base == NO_BASE), result.data.next_base == NO_BASE)
    `PKC_ASSERT_IMPL(distinct_bases_a, clk, rst_n, result.valid && (result.data.top_base != NO_BASE) && (result.data.next_base != NO_BASE), result.data.top_base != result.data.next_base)

endmodule

>>> src/pkc_queue.sv
// ---------------------------------------------------------------------------
// Pileup base counter operation queue
// Short register queue between the parser and the counter bank.
// ---------------------------------------------------------------------------
module pkc_queue import pkc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  op_t   push_op,
    output logic  full,
    input  logic  pop,
    output q_rd_t rd
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    op_t                 mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg;
    logic [CNT_BITS-1:0] fill_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (fill_reg == CNT_BITS'(QUEUE_DEPTH));
    assign rd.valid = (fill_reg != '0);
    assign rd.op    = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> src/pkc_front.sv
// ---------------------------------------------------------------------------
// Pileup base counter front end
// Parses pileup items and issues count and end-of-position operations.
// ---------------------------------------------------------------------------
module pkc_front import pkc_pkg::*;
#(
    parameter int INDEL_BITS = DEFAULT_INDEL_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [QUAL_BITS-1:0] cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    output logic                 push,
    output op_t                  push_op,
    input  logic                 queue_full
);

    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_SKIP_ONE = 2'd1;
    localparam logic [1:0] MODE_DIGITS   = 2'd2;
    localparam logic [1:0] MODE_SKIP_RUN = 2'd3;

    localparam logic [7:0] CHR_CARET  = 8'h5E;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_MINUS  = 8'h2D;
    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] QUAL_ZERO  = 8'h21;

    localparam int NUM_BITS = INDEL_BITS + 4;

    typedef struct packed {
        logic       hit;
        logic [1:0] code;
    } base_dec_t;

    function automatic base_dec_t decode_base(input logic [7:0] c);
        base_dec_t d;
        d.hit  = 1'b1;
        d.code = 2'd0;
        case (c)
            8'h41, 8'h61: d.code = 2'd0;
            8'h54, 8'h74: d.code = 2'd1;
            8'h47, 8'h67: d.code = 2'd2;
            8'h43, 8'h63: d.code = 2'd3;
            default:      d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    logic [QUAL_BITS-1:0]  min_qual_reg;
    logic [1:0]            ref_code_reg;
    logic [1:0]            ref_code_next;
    logic [1:0]            mode_reg;
    logic [1:0]            mode_next;
    logic [INDEL_BITS-1:0] remain_reg;
    logic [INDEL_BITS-1:0] remain_next;
    logic                  seen_reg;
    logic                  seen_next;

    logic                  accept;
    logic                  take_sym;
    logic                  is_digit;
    logic [NUM_BITS-1:0]   number;
    logic [INDEL_BITS-1:0] remain_dec;
    logic                  qual_ok;
    base_dec_t             sym_dec;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign sym_dec    = decode_base(item.symbol);
    assign is_digit   = (item.symbol >= CHR_ZERO) && (item.symbol <= CHR_NINE);
    assign number     = NUM_BITS'(remain_reg) * NUM_BITS'(4'd10)
                        + NUM_BITS'(item.symbol[3:0]);
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;
    assign qual_ok    = (min_qual_reg == '0)
                        || ((item.quality_char >= QUAL_ZERO)
                            && ((item.quality_char - QUAL_ZERO) >= {1'b0, min_qual_reg}));

    always_comb
    begin
        ref_code_next    = ref_code_reg;
        mode_next        = mode_reg;
        remain_next      = remain_reg;
        seen_next        = seen_reg;
        take_sym         = 1'b0;
        push             = 1'b0;
        push_op.kind     = OP_COUNT;
        push_op.sample   = item.sample;
        push_op.base     = sym_dec.code;
        push_op.ref_code = ref_code_reg;
        push_op.seen     = seen_reg;
        if (accept)
        begin
            case (item.action)
                ACT_REF:
                begin
                    if (sym_dec.hit)
                    begin
                        ref_code_next = sym_dec.code;
                    end
                end
                ACT_SYMBOL:
                begin
                    if (item.sample)
                    begin
                        seen_next = 1'b1;
                    end
                    case (mode_reg)
                        MODE_SKIP_ONE:
                        begin
                            mode_next = MODE_NORMAL;
                        end
                        MODE_SKIP_RUN:
                        begin
                            remain_next = remain_dec;
                            if (remain_dec == '0)
                            begin
                                mode_next = MODE_NORMAL;
                            end
                        end
                        MODE_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                remain_next = (number[NUM_BITS-1:INDEL_BITS] != '0)
                                              ? '1 : number[INDEL_BITS-1:0];
                            end
                            else if (remain_reg != '0)
                            begin
                                remain_next = remain_dec;
                                mode_next   = (remain_dec != '0) ? MODE_SKIP_RUN : MODE_NORMAL;
                            end
                            else
                            begin
                                mode_next = MODE_NORMAL;
                                take_sym  = 1'b1;
                            end
                        end
                        default:
                        begin
                            take_sym = 1'b1;
                        end
                    endcase
                    if (take_sym)
                    begin
                        if (item.symbol == CHR_CARET)
                        begin
                            mode_next = MODE_SKIP_ONE;
                        end
                        else if ((item.symbol == CHR_PLUS) || (item.symbol == CHR_MINUS))
                        begin
                            mode_next   = MODE_DIGITS;
                            remain_next = '0;
                        end
                        else if ((item.symbol != CHR_DOLLAR) && (item.symbol != CHR_STAR)
                                 && qual_ok)
                        begin
                            if (sym_dec.hit)
                            begin
                                push = 1'b1;
                            end
                            else if ((item.symbol == CHR_DOT) || (item.symbol == CHR_COMMA))
                            begin
                                push         = 1'b1;
                                push_op.base = ref_code_reg;
                            end
                        end
                    end
                end
                ACT_END:
                begin
                    push         = 1'b1;
                    push_op.kind = OP_END;
                    mode_next    = MODE_NORMAL;
                    remain_next  = '0;
                    seen_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_qual_reg <= '0;
            ref_code_reg <= '0;
            mode_reg     <= MODE_NORMAL;
            remain_reg   <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_qual_reg <= cfg_data;
            end
            ref_code_reg <= ref_code_next;
            mode_reg     <= mode_next;
            remain_reg   <= remain_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

>>> src/pkc_back.sv
// ---------------------------------------------------------------------------
// Pileup base counter back end
// Saturating per-sample base counters, then a sum stage and a rank stage.
// ---------------------------------------------------------------------------
module pkc_back import pkc_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_rd_t     q,
    output logic      pop,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    localparam int SUM_BITS = COUNT_BITS + 1;

    logic [COUNT_BITS-1:0] cnt_reg [8];
    logic [COUNT_BITS-1:0] first_reg [4];
    logic [COUNT_BITS-1:0] second_reg [4];
    logic [SUM_BITS-1:0]   sum_reg [4];
    logic [1:0]            s1_ref_reg;
    logic                  s1_valid_reg;
    logic                  res_valid_reg;
    out_item_t             res_reg;
    out_item_t             res_next;

    logic                  s1_advance;
    logic                  s1_free;
    logic                  do_count;
    logic                  do_end;
    logic [2:0]            cnt_idx;

    logic [SUM_BITS-1:0]   best;
    logic [SUM_BITS-1:0]   runner;
    logic [2:0]            best_idx;
    logic [2:0]            runner_idx;
    logic [COUNT_BITS-1:0] best_first;
    logic [COUNT_BITS-1:0] best_second;
    logic [COUNT_BITS-1:0] runner_first;
    logic [COUNT_BITS-1:0] runner_second;

    assign s1_advance = s1_valid_reg && (!res_valid_reg || res_ready);
    assign s1_free    = !s1_valid_reg || s1_advance;
    assign pop        = q.valid && ((q.op.kind == OP_COUNT) || s1_free);
    assign do_count   = pop && (q.op.kind == OP_COUNT);
    assign do_end     = pop && (q.op.kind == OP_END);
    assign cnt_idx    = {q.op.sample, q.op.base};
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cnt_reg[i] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (do_end)
                begin
                    cnt_reg[i] <= '0;
                end
                else if (do_count && (cnt_idx == 3'(i)) && !(&cnt_reg[i]))
                begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
            end
            if (do_end)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_end)
        begin
            s1_ref_reg <= q.op.ref_code;
            for (int j = 0; j < 4; j++)
            begin
                first_reg[j]  <= cnt_reg[j];
                second_reg[j] <= q.op.seen ? cnt_reg[j + 4] : cnt_reg[j];
                sum_reg[j]    <= SUM_BITS'(cnt_reg[j])
                                 + SUM_BITS'(q.op.seen ? cnt_reg[j + 4] : cnt_reg[j]);
            end
        end
        if (s1_advance)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        best          = '0;
        runner        = '0;
        best_idx      = NO_BASE;
        runner_idx    = NO_BASE;
        best_first    = '0;
        best_second   = '0;
        runner_first  = '0;
        runner_second = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (sum_reg[j] > best)
            begin
                runner        = best;
                runner_idx    = best_idx;
                runner_first  = best_first;
                runner_second = best_second;
                best          = sum_reg[j];
                best_idx      = 3'(j);
                best_first    = first_reg[j];
                best_second   = second_reg[j];
            end
            else if (sum_reg[j] > runner)
            begin
                runner        = sum_reg[j];
                runner_idx    = 3'(j);
                runner_first  = first_reg[j];
                runner_second = second_reg[j];
            end
        end
        res_next.ref_code          = s1_ref_reg;
        res_next.top_base          = best_idx;
        res_next.top_count_first   = OUT_COUNT_BITS'(best_first);
        res_next.top_count_second  = OUT_COUNT_BITS'(best_second);
        res_next.next_base         = runner_idx;
        res_next.next_count_first  = OUT_COUNT_BITS'(runner_first);
        res_next.next_count_second = OUT_COUNT_BITS'(runner_second);
    end

endmodule

>>> verif/pileup_base_counter_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pileup base counter checker
// Watches the configuration, pileup and result channels of the counter. It
// keeps its own copy of the parser, the per-sample base tallies and the
// quality threshold, predicts the call made at each end of position and
// compares every accepted result with the oldest predicted call.
// ---------------------------------------------------------------------------
module pileup_base_counter_checker import pkc_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
    parameter int INDEL_BITS = DEFAULT_INDEL_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    pkc_cfg_if   cfg,
    pkc_in_if    pileup,
    pkc_out_if   result,
    output int   errors,
    output int   pending,
    output int   results_seen
);

    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_SKIP_ONE,
        PM_DIGITS,
        PM_SKIP_RUN
    } parse_mode_t;

    typedef enum int {
        BASE_A,
        BASE_T,
        BASE_G,
        BASE_C
    } base_t;

    localparam int         MAX_SHOWN  = 10;
    localparam int         INDEL_MAX  = (1 << INDEL_BITS) - 1;
    localparam logic [7:0] PHRED_ZERO = "!";
    localparam logic [7:0] DIGIT_ZERO = "0";

    logic [COUNT_BITS-1:0] tally [8];
    logic [1:0]            ref_base;
    parse_mode_t           mode;
    int                    indel_left;
    logic                  tumour_seen;
    logic [QUAL_BITS-1:0]  qual_floor;
    out_item_t             calls_due [$];

    function automatic int base_index(logic [7:0] c);
        case (c)
            "A", "a": return BASE_A;
            "T", "t": return BASE_T;
            "G", "g": return BASE_G;
            "C", "c": return BASE_C;
            default:  return -1;
        endcase
    endfunction

    function automatic string fmt_call(out_item_t c);
        return $sformatf("ref %0d top %0d %0d/%0d next %0d %0d/%0d",
                         c.ref_code, c.top_base, c.top_count_first, c.top_count_second,
                         c.next_base, c.next_count_first, c.next_count_second);
    endfunction

    task automatic clear_position();
        int j;
        for (j = 0; j < 8; j++)
        begin
            tally[j] = '0;
        end
        mode        = PM_NORMAL;
        indel_left  = 0;
        tumour_seen = 1'b0;
    endtask

    task automatic count_base(logic s, logic [7:0] sym, logic [7:0] qc);
        int         q;
        int         b;
        logic [2:0] idx;
        q = int'(qc) - int'(PHRED_ZERO);
        if (qual_floor != 0 && q < int'(qual_floor))
            return;
        b = base_index(sym);
        if (b < 0)
        begin
            if (sym == "." || sym == ",")
                b = int'(ref_base);
            else
                return;
        end
        idx = {s, 2'(b)};
        if (tally[idx] != '1)
            tally[idx] = tally[idx] + 1'b1;
    endtask

    task automatic parse_symbol(logic s, logic [7:0] sym, logic [7:0] qc);
        int n;
        if (s)
            tumour_seen = 1'b1;
        case (mode)
            PM_SKIP_ONE:
            begin
                mode = PM_NORMAL;
                return;
            end
            PM_SKIP_RUN:
            begin
                if (indel_left > 0)
                    indel_left--;
                if (indel_left == 0)
                    mode = PM_NORMAL;
                return;
            end
            PM_DIGITS:
            begin
                if (sym >= "0" && sym <= "9")
                begin
                    n = indel_left * 10 + int'(sym - DIGIT_ZERO);
                    indel_left = (n > INDEL_MAX) ? INDEL_MAX : n;
                    return;
                end
                if (indel_left > 0)
                begin
                    indel_left--;
                    mode = (indel_left != 0) ? PM_SKIP_RUN : PM_NORMAL;
                    return;
                end
                mode = PM_NORMAL;
            end
            default:
            begin
            end
        endcase
        if (sym == "^")
        begin
            mode = PM_SKIP_ONE;
        end
        else if (sym == "+" || sym == "-")
        begin
            mode       = PM_DIGITS;
            indel_left = 0;
        end
        else if (sym != "$" && sym != "*")
        begin
            count_base(s, sym, qc);
        end
    endtask

    task automatic close_position();
        longint    best;
        longint    runner;
        longint    c;
        int        bi;
        int        si;
        int        off;
        int        j;
        out_item_t call;
        best   = 0;
        runner = 0;
        bi     = NO_BASE;
        si     = NO_BASE;
        off    = tumour_seen ? 4 : 0;
        for (j = 0; j < 4; j++)
        begin
            c = longint'(tally[j]) + longint'(tally[j + off]);
            if (c > best)
            begin
                si     = bi;
                runner = best;
                bi     = j;
                best   = c;
            end
            else if (c > runner)
            begin
                si     = j;
                runner = c;
            end
        end
        call          = '0;
        call.ref_code = ref_base;
        call.top_base = 3'(bi);
        call.next_base = 3'(si);
        if (bi < 4)
        begin
            call.top_count_first  = OUT_COUNT_BITS'(tally[bi]);
            call.top_count_second = OUT_COUNT_BITS'(tally[bi + off]);
        end
        if (si < 4)
        begin
            call.next_count_first  = OUT_COUNT_BITS'(tally[si]);
            call.next_count_second = OUT_COUNT_BITS'(tally[si + off]);
        end
        calls_due.push_back(call);
        clear_position();
    endtask

    task automatic advance_position(in_item_t it);
        int b;
        case (it.action)
            ACT_REF:
            begin
                b = base_index(it.symbol);
                if (b >= 0)
                    ref_base = 2'(b);
            end
            ACT_SYMBOL:
            begin
                parse_symbol(it.sample, it.symbol, it.quality_char);
            end
            ACT_END:
            begin
                close_position();
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t due;
        out_item_t got;
        logic      bad;
        if (!rst_n)
        begin
            clear_position();
            ref_base     = '0;
            qual_floor   = '0;
            errors       = 0;
            results_seen = 0;
            calls_due.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = result.data;
                results_seen++;
                if (calls_due.size() == 0)
                begin
                    if (errors < MAX_SHOWN)
                        $display("pileup_base_counter_checker: unexpected call %s",
                                 fmt_call(got));
                    errors++;
                end
                else
                begin
                    due = calls_due.pop_front();
                    bad = (got.ref_code !== due.ref_code)
                        || (got.top_base !== due.top_base)
                        || (got.top_count_first !== due.top_count_first)
                        || (got.top_count_second !== due.top_count_second)
                        || (got.next_base !== due.next_base)
                        || (got.next_count_first !== due.next_count_first)
                        || (got.next_count_second !== due.next_count_second);
                    if (bad)
                    begin
                        if (errors < MAX_SHOWN)
                            $display("pileup_base_counter_checker: call mismatch, expected %s, got %s",
                                     fmt_call(due), fmt_call(got));
                        errors++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                qual_floor = cfg.data;
            if (pileup.valid && pileup.ready)
                advance_position(pileup.data);
        end
        pending = calls_due.size();
    end

endmodule

>>> verif/pileup_base_counter_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pileup base counter testbench
// Drives directed pileup requests covering the parser corner cases, then
// random well-formed positions with some noise, under three mixes of
// sender and receiver stalls and several quality thresholds. A checker
// beside the block predicts and compares every call.
// ---------------------------------------------------------------------------
module pileup_base_counter_top_tb;
    import pkc_pkg::*;

    localparam logic [1:0] ACT_SPARE      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 12;
    localparam int         BLOCK_ITEMS    = 140;
    localparam logic [7:0] DIGIT_ZERO     = "0";
    localparam logic [7:0] READ_CHARS [10] = '{"A", "T", "G", "C", "a", "t", "g", "c", ".", ","};
    localparam logic [7:0] SEQ_CHARS  [10] = '{"A", "C", "G", "T", "N", "a", "c", "g", "t", "n"};

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 pileup_valid = 1'b0;
    in_item_t             pileup_data  = '0;
    logic                 cfg_valid    = 1'b0;
    logic [QUAL_BITS-1:0] cfg_data     = '0;
    logic                 rx_ready     = 1'b0;
    logic [QUAL_BITS-1:0] min_qual_now = '0;
    int                   tx_idle_pct  = 0;
    int                   rx_idle_pct  = 0;
    int                   items_sent   = 0;
    int                   cfg_writes   = 0;
    int                   stall_cycles = 0;
    int                   errors;
    int                   pending;
    int                   results_seen;

    pkc_cfg_if cfg_ch ();
    pkc_in_if  pileup_ch ();
    pkc_out_if result_ch ();

    assign cfg_ch.valid    = cfg_valid;
    assign cfg_ch.data     = cfg_data;
    assign pileup_ch.valid = pileup_valid;
    assign pileup_ch.data  = pileup_data;
    assign result_ch.ready = rx_ready;

    pileup_base_counter_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pileup (pileup_ch),
        .result (result_ch)
    );

    pileup_base_counter_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_ch),
        .pileup       (pileup_ch),
        .result       (result_ch),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pileup_valid && pileup_ch.ready) || (cfg_valid && cfg_ch.ready)
                || (result_ch.valid && rx_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("pileup_base_counter_top_tb: no request moved for %0d cycles",
                         WATCHDOG_LIMIT);
                $display("pileup_base_counter_top_tb: errors");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic in_item_t mk(logic [1:0] a, logic s, logic [7:0] sym, logic [7:0] q);
        in_item_t it;
        it.action       = a;
        it.sample       = s;
        it.symbol       = sym;
        it.quality_char = q;
        return it;
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_quality();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(33, 126));
        if (r < 80)
            return 8'(32 + int'(min_qual_now) + $urandom_range(0, 2));
        return rand8();
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pileup_valid <= 1'b0;
            @(negedge clk);
        end
        pileup_valid <= 1'b1;
        pileup_data  <= it;
        do @(posedge clk); while (!pileup_ch.ready);
        items_sent++;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        pileup_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_min_qual(logic [QUAL_BITS-1:0] v);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_valid    <= 1'b0;
        min_qual_now = v;
        cfg_writes++;
    endtask

    task automatic send_indel(logic s);
        int         len;
        int         shown;
        int         k;
        logic [7:0] sign;
        len   = $urandom_range(1, 15);
        sign  = ($urandom_range(0, 1) != 0) ? 8'("+") : 8'("-");
        shown = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        send_item(mk(ACT_SYMBOL, s, sign, rand8()));
        if ($urandom_range(0, 7) == 0)
            send_item(mk(ACT_SYMBOL, s, DIGIT_ZERO, rand8()));
        if (len >= 10)
        begin
            send_item(mk(ACT_SYMBOL, s, 8'(DIGIT_ZERO + 1), rand8()));
            send_item(mk(ACT_SYMBOL, s, 8'(DIGIT_ZERO + len - 10), rand8()));
        end
        else
        begin
            send_item(mk(ACT_SYMBOL, s, 8'(DIGIT_ZERO + len), rand8()));
        end
        for (k = 0; k < shown; k++)
        begin
            send_item(mk(ACT_SYMBOL, s, SEQ_CHARS[$urandom_range(0, 9)], rand8()));
        end
    endtask

    task automatic send_reads(logic s, int tokens);
        int k;
        int r;
        for (k = 0; k < tokens; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                send_item(mk(ACT_SYMBOL, s, READ_CHARS[$urandom_range(0, 9)], pick_quality()));
            end
            else if (r < 70)
            begin
                send_item(mk(ACT_SYMBOL, s, "^", rand8()));
                send_item(mk(ACT_SYMBOL, s, rand8(), rand8()));
            end
            else if (r < 78)
            begin
                send_item(mk(ACT_SYMBOL, s, ($urandom_range(0, 1) != 0) ? 8'("$") : 8'("*"),
                             rand8()));
            end
            else if (r < 90)
            begin
                send_indel(s);
            end
            else if (r < 95)
            begin
                send_item(mk(ACT_SYMBOL, s, ($urandom_range(0, 1) != 0) ? 8'("N") : 8'("n"),
                             pick_quality()));
            end
            else
            begin
                send_item(mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             rand8(), rand8()));
            end
        end
    endtask

    task automatic send_position();
        send_item(mk(ACT_REF, 1'($urandom_range(0, 1)), READ_CHARS[$urandom_range(0, 7)],
                     rand8()));
        send_reads(1'b0, $urandom_range(1, 12));
        if ($urandom_range(0, 3) != 0)
            send_reads(1'b1, $urandom_range(1, 12));
        if ($urandom_range(0, 9) == 0)
            send_reads(1'b0, $urandom_range(1, 4));
        send_item(mk(ACT_END, 1'($urandom_range(0, 1)), rand8(), rand8()));
    endtask

    initial
    begin : stimulus
        int phase;
        int blk;
        int target;
        logic [QUAL_BITS-1:0] qv;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 19;
        rx_idle_pct = 56;

        send_item(mk(ACT_REF, 1'b0, "G", 8'h00));
        send_item(mk(ACT_SYMBOL, 1'b0, "A", "~"));
        send_item(mk(ACT_SYMBOL, 1'b0, "c", 8'h00));
        send_item(mk(ACT_SYMBOL, 1'b0, ".", "I"));
        send_item(mk(ACT_SYMBOL, 1'b0, ",", 8'hff));
        send_item(mk(ACT_SYMBOL, 1'b0, "^", "]"));
        send_item(mk(ACT_SYMBOL, 1'b1, "A", "~"));
        send_item(mk(ACT_SYMBOL, 1'b0, "$", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "*", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "+", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "2", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "A", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "C", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "-", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "0", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "t", "]"));
        send_item(mk(ACT_SYMBOL, 1'b0, "+", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "g", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "N", "5"));
        send_item(mk(ACT_REF, 1'b1, "N", 8'hff));
        send_item(mk(ACT_SYMBOL, 1'b1, "T", "g"));
        send_item(mk(ACT_SPARE, 1'b1, 8'hff, 8'hff));
        send_item(mk(ACT_END, 1'b0, 8'h00, 8'h00));
        send_item(mk(ACT_END, 1'b1, 8'hff, 8'hff));
        send_item(mk(ACT_SYMBOL, 1'b0, "-", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "9", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "9", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "9", "5"));
        send_item(mk(ACT_SYMBOL, 1'b0, "9", "5"));
        send_item(mk(ACT_END, 1'b0, 8'h00, 8'h00));

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                tx_idle_pct = 56;
                rx_idle_pct = 19;
            end
            else if (phase == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (blk = 0; blk < 2; blk++)
            begin
                case (phase * 2 + blk)
                    0:       qv = 7'd93;
                    1:       qv = 7'd0;
                    2:       qv = 7'd1;
                    3:       qv = 7'd20;
                    default: qv = 7'($urandom_range(0, 93));
                endcase
                write_min_qual(qv);
                target = items_sent + BLOCK_ITEMS;
                while (items_sent < target)
                    send_position();
            end
        end

        wait_quiet();
        $display("pileup_base_counter_top_tb: %0d pileup requests, %0d calls checked, %0d threshold writes",
                 items_sent, results_seen, cfg_writes);
        $display("pileup_base_counter_top_tb: stall mixes 19/56, 56/19 and none; thresholds 0 to 93");
        if (errors == 0)
        begin
            $display("pileup_base_counter_top_tb: clean");
        end
        else
        begin
            $display("pileup_base_counter_top_tb: errors");
        end
        $finish;
    end

endmodule

>>> pileup_base_counter_top.f
+incdir+src
src/pkc_pkg.sv
src/pkc_if.sv
src/pkc_queue.sv
src/pkc_front.sv
src/pkc_back.sv
src/pileup_base_counter_top.sv
verif/pileup_base_counter_checker.sv
verif/pileup_base_counter_top_tb.sv
